// ===== rtl/hlcd_pkg.sv =====
// hlcd_pkg: shared constants, types and register indexes of the frame deframer
// used by every rtl file of the block; depends on nothing
package hlcd_pkg;

   // frame store depth and derived widths
   localparam int MAX_FRAME      = 32;
   localparam int FRAME_OVERHEAD = 3;
   localparam int MAX_LIMIT      = MAX_FRAME - FRAME_OVERHEAD;
   localparam int IDX_W          = $clog2(MAX_FRAME);
   localparam int CNT_W          = $clog2(MAX_FRAME + 1);

   // fixed field widths
   localparam int BYTE_W     = 8;
   localparam int POS_W      = 5;
   localparam int LEN_W      = 5;
   localparam int LIMIT_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_HEADER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_HEADER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_LIMIT = 2'd2;

   // register reset values
   localparam logic [BYTE_W-1:0]  FIRST_HEADER_RST  = 8'd170;
   localparam logic [BYTE_W-1:0]  SECOND_HEADER_RST = 8'd85;
   localparam logic [LIMIT_W-1:0] PAYLOAD_LIMIT_RST = 5'd29;

   // parser phases
   typedef enum logic [2:0] {
      PH_HEAD0,
      PH_HEAD1,
      PH_LEN,
      PH_DATA,
      PH_SUM,
      PH_EMIT
   } hlcd_phase_type;

   // controller to datapath commands
   typedef struct packed {
      logic keep;
      logic clear;
      logic load_len;
      logic rd_en;
   } hlcd_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_head0;
      logic is_head1;
      logic len_ok;
      logic len_zero;
      logic data_done;
      logic sum_ok;
      logic rd_last;
      logic rd_free;
   } hlcd_sts_type;

endpackage

// ===== rtl/hlcd_if.sv =====
// hlcd_req_if / hlcd_rsp_if: valid-ready channels for received bytes and frame bytes
// depends on hlcd_pkg for field widths
interface hlcd_req_if import hlcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface hlcd_rsp_if import hlcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte;
   logic [POS_W-1:0]  byte_position;
   logic              last_of_frame;

   modport source (output valid, output frame_byte, output byte_position,
                   output last_of_frame, input ready);
   modport sink (input valid, input frame_byte, input byte_position,
                 input last_of_frame, output ready);
endinterface

// ===== rtl/hlcd_ctrl.sv =====
// hlcd_ctrl: parser state machine, issues store, clear and readout commands
// depends on hlcd_pkg
module hlcd_ctrl import hlcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  hlcd_sts_type sts,
   output hlcd_cmd_type cmd
);

   hlcd_phase_type state_ff;
   hlcd_phase_type state_in;
   logic           acc;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_HEAD0;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff != PH_EMIT);
      acc       = req_valid && req_ready;
      case (state_ff)
         PH_HEAD0: begin
            if (acc && sts.is_head0) begin
               cmd.keep = 1'b1;
               state_in = PH_HEAD1;
            end
         end
         PH_HEAD1: begin
            if (acc) begin
               if (sts.is_head1) begin
                  cmd.keep = 1'b1;
                  state_in = PH_LEN;
               end else begin
                  cmd.clear = 1'b1;
                  state_in  = PH_HEAD0;
               end
            end
         end
         PH_LEN: begin
            if (acc) begin
               if (sts.len_ok) begin
                  cmd.keep     = 1'b1;
                  cmd.load_len = 1'b1;
                  state_in     = sts.len_zero ? PH_SUM : PH_DATA;
               end else begin
                  cmd.clear = 1'b1;
                  state_in  = PH_HEAD0;
               end
            end
         end
         PH_DATA: begin
            if (acc) begin
               cmd.keep = 1'b1;
               if (sts.data_done) begin
                  state_in = PH_SUM;
               end
            end
         end
         PH_SUM: begin
            if (acc) begin
               if (sts.sum_ok) begin
                  state_in = PH_EMIT;
               end else begin
                  cmd.clear = 1'b1;
                  state_in  = PH_HEAD0;
               end
            end
         end
         PH_EMIT: begin
            // one store read per free slot, last read ends the frame
            if (sts.rd_free) begin
               cmd.rd_en = 1'b1;
               if (sts.rd_last) begin
                  cmd.clear = 1'b1;
                  state_in  = PH_HEAD0;
               end
            end
         end
         default: begin
            cmd.clear = 1'b1;
            state_in  = PH_HEAD0;
         end
      endcase
   end

endmodule

// ===== rtl/hlcd_dpath.sv =====
// hlcd_dpath: config registers, frame store, counters, checksum and readout pipeline
// depends on hlcd_pkg and hlcd_rsp_if
module hlcd_dpath import hlcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [BYTE_W-1:0]     rx_byte,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  hlcd_cmd_type          cmd,
   output hlcd_sts_type          sts,
   hlcd_rsp_if.source            rsp_ch
);

   logic [BYTE_W-1:0]  first_hdr_ff;
   logic [BYTE_W-1:0]  second_hdr_ff;
   logic [LIMIT_W-1:0] limit_ff;

   logic [BYTE_W-1:0]  store_mem [MAX_FRAME];
   logic [CNT_W-1:0]   fill_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [BYTE_W-1:0]  sum_ff;
   logic [CNT_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   rd_ptr_nx;

   logic               rd_valid_ff;
   logic [BYTE_W-1:0]  rd_data_ff;
   logic [POS_W-1:0]   rd_pos_ff;
   logic               rd_last_ff;

   logic               out_valid_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic [POS_W-1:0]   out_pos_ff;
   logic               out_last_ff;

   logic [BYTE_W-1:0]  eff_limit;
   logic               advance;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         first_hdr_ff  <= FIRST_HEADER_RST;
         second_hdr_ff <= SECOND_HEADER_RST;
         limit_ff      <= PAYLOAD_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIRST_HEADER:  first_hdr_ff  <= csr_wdata;
            CSR_SECOND_HEADER: second_hdr_ff <= csr_wdata;
            CSR_PAYLOAD_LIMIT: limit_ff      <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // limit saturated so a frame always fits the store
   assign eff_limit = (BYTE_W'(limit_ff) > BYTE_W'(MAX_LIMIT)) ?
                      BYTE_W'(MAX_LIMIT) : BYTE_W'(limit_ff);

   // frame store write
   always_ff @(posedge clock) begin
      if (cmd.keep && (fill_ff < CNT_W'(MAX_FRAME))) begin
         store_mem[fill_ff[IDX_W-1:0]] <= rx_byte;
      end
   end

   // fill count, length and running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         len_ff  <= '0;
         sum_ff  <= '0;
      end else begin
         if (cmd.clear) begin
            fill_ff <= '0;
            sum_ff  <= '0;
         end else if (cmd.keep) begin
            if (fill_ff < CNT_W'(MAX_FRAME)) begin
               fill_ff <= fill_ff + CNT_W'(1);
            end
            sum_ff <= sum_ff + rx_byte;
         end
         if (cmd.load_len) begin
            len_ff <= rx_byte[LEN_W-1:0];
         end
      end
   end

   // readout pointer
   assign rd_ptr_nx = rd_ptr_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
      end else if (cmd.rd_en) begin
         rd_ptr_ff <= (rd_ptr_nx == fill_ff) ? '0 : rd_ptr_nx;
      end
   end

   // store read stage
   assign advance = rd_valid_ff && (!out_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[rd_ptr_ff[IDX_W-1:0]];
         rd_pos_ff  <= POS_W'(rd_ptr_ff);
         rd_last_ff <= (rd_ptr_nx == fill_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (cmd.rd_en) begin
         rd_valid_ff <= 1'b1;
      end else if (advance) begin
         rd_valid_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff <= rd_data_ff;
         out_pos_ff  <= rd_pos_ff;
         out_last_ff <= rd_last_ff;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.frame_byte    = out_byte_ff;
   assign rsp_ch.byte_position = out_pos_ff;
   assign rsp_ch.last_of_frame = out_last_ff;

   // status to the controller
   always_comb begin
      sts.is_head0  = (rx_byte == first_hdr_ff);
      sts.is_head1  = (rx_byte == second_hdr_ff);
      sts.len_ok    = (rx_byte <= eff_limit);
      sts.len_zero  = (rx_byte == '0);
      sts.data_done = ({1'b0, fill_ff} >=
                       ((CNT_W+1)'(len_ff) + (CNT_W+1)'(FRAME_OVERHEAD - 1)));
      sts.sum_ok    = (rx_byte == sum_ff);
      sts.rd_last   = (rd_ptr_nx == fill_ff);
      sts.rd_free   = !rd_valid_ff || advance;
   end

endmodule

// ===== rtl/header_length_checksum_deframer.sv =====
// header_length_checksum_deframer: top level, joins the parser controller and datapath
// depends on hlcd_pkg, hlcd_if, hlcd_ctrl and hlcd_dpath
//
// Usage:
//   req_ch carries received bytes, one per accepted request (valid and ready high).
//   The parser hunts for the two header bytes, takes a length byte (dropped and
//   hunting resumed when above the payload limit), stores the payload and checks
//   the following checksum byte against the 8-bit sum of headers, length and payload.
//   A good frame comes out on rsp_ch as one request per stored byte (checksum not
//   included) with its position and a last flag; a bad frame gives nothing.
//   req_ch.ready stays high while a frame is being parsed.
//   After a good checksum the block reads the frame store out at one byte per cycle
//   while the receiver keeps up, and holds req_ch.ready low through the readout
//   of all the frame's bytes (frame length plus three); the first result passes
//   the read stage and the output register. The store's single read port sets
//   that readout rate. A stalled receiver stops the readout: an output register and
//   a read stage hold results, and the request channel stays closed until the last
//   read is issued. csr_we writes register csr_index (0 first header, 1 second
//   header, 2 payload limit); the user must write only while the block is idle,
//   and the block has no check for it. Reset (synchronous, active high) returns
//   to header hunting, clears the output and loads the register defaults 170, 85 and 29.
module header_length_checksum_deframer import hlcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   hlcd_req_if.sink              req_ch,
   hlcd_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   hlcd_cmd_type cmd;
   hlcd_sts_type sts;
   logic         req_ready;

   // parser controller
   hlcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_ch.ready = req_ready;

   // datapath
   hlcd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .rx_byte   (req_ch.rx_byte),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ch    (rsp_ch)
   );

   // readout never overlaps taking a request
   a_rd_no_req: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> !req_ready)
      else $error("store read issued while requests are taken");

   // a byte is never stored and cleared together
   a_keep_clear: assert property (@(posedge clock) disable iff (reset)
      !(cmd.keep && cmd.clear))
      else $error("store and clear in the same cycle");

   // a byte is stored only from an accepted request
   a_keep_acc: assert property (@(posedge clock) disable iff (reset)
      cmd.keep |-> (req_ch.valid && req_ready))
      else $error("byte stored without an accepted request");

endmodule

// ===== verif/tb.sv =====
// tb: self-checking testbench for header_length_checksum_deframer, byte stream in, frame bytes out
// depends on hlcd_pkg, hlcd_req_if / hlcd_rsp_if and the deframer top level
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hlcd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 40;
   localparam int QUIET_LIMIT   = 1000;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [POS_W-1:0]  pos;
      logic              last;
   } frame_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   hlcd_req_if req_if ();
   hlcd_rsp_if rsp_if ();

   header_length_checksum_deframer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies used for prediction and stimulus
   logic [BYTE_W-1:0]  cfg_first;
   logic [BYTE_W-1:0]  cfg_second;
   logic [LIMIT_W-1:0] cfg_limit;

   // tracked parser state
   hlcd_phase_type     trk_phase;
   logic [BYTE_W-1:0]  trk_store [MAX_FRAME];
   logic [5:0]         trk_fill;
   logic [LEN_W-1:0]   trk_len;
   logic [BYTE_W-1:0]  trk_sum;

   logic [BYTE_W-1:0]  rx_bytes_pending [$];
   frame_beat_type     frame_beats_due [$];
   frame_beat_type     seen_beat;
   frame_beat_type     due_beat;

   bit sender_calm   = 1'b0;
   bit receiver_calm = 1'b0;
   int gap_left      = 0;
   int stall_left    = 0;
   int quiet_cycles  = 0;
   int items_queued  = 0;
   int bytes_taken   = 0;
   int beats_checked = 0;
   int frames_passed = 0;
   int csr_writes    = 0;
   int errors        = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly no gap, some short ones, a few long
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 70) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // length limit saturated so a frame always fits the store
   function automatic logic [LIMIT_W-1:0] eff_limit();
      return (cfg_limit > MAX_LIMIT) ? LIMIT_W'(MAX_LIMIT) : cfg_limit;
   endfunction

   task automatic restart_hunt();
      trk_phase = PH_HEAD0;
      trk_fill  = '0;
      trk_sum   = '0;
   endtask

   task automatic store_byte(input logic [BYTE_W-1:0] b);
      if (trk_fill < MAX_FRAME) begin
         trk_store[trk_fill[IDX_W-1:0]] = b;
         trk_fill = trk_fill + 6'd1;
      end
      trk_sum = trk_sum + b;
   endtask

   // advance the tracked parser by one received byte, queue any frame bytes it releases
   task automatic deframe_byte(input logic [BYTE_W-1:0] b);
      frame_beat_type beat;
      int i;
      case (trk_phase)
         PH_HEAD1: begin
            if (b == cfg_second) begin
               store_byte(b);
               trk_phase = PH_LEN;
            end else begin
               restart_hunt();
            end
         end
         PH_LEN: begin
            if (b <= eff_limit()) begin
               trk_len = b[LEN_W-1:0];
               store_byte(b);
               trk_phase = (b == 0) ? PH_SUM : PH_DATA;
            end else begin
               restart_hunt();
            end
         end
         PH_DATA: begin
            store_byte(b);
            if (trk_fill >= trk_len + 3) trk_phase = PH_SUM;
         end
         PH_SUM: begin
            if (b == trk_sum) begin
               for (i = 0; i < trk_fill; i++) begin
                  beat.data = trk_store[i[IDX_W-1:0]];
                  beat.pos  = POS_W'(i);
                  beat.last = (i + 1 == trk_fill);
                  frame_beats_due.push_back(beat);
               end
               frames_passed++;
            end
            restart_hunt();
         end
         default: begin
            restart_hunt();
            if (b == cfg_first) begin
               store_byte(b);
               trk_phase = PH_HEAD1;
            end
         end
      endcase
   endtask

   // request driver: feeds queued bytes, predicts on every accepted request
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left <= 0;
         cfg_first  = FIRST_HEADER_RST;
         cfg_second = SECOND_HEADER_RST;
         cfg_limit  = PAYLOAD_LIMIT_RST;
         trk_len    = '0;
         restart_hunt();
      end else begin
         if (req_if.valid && req_if.ready) begin
            deframe_byte(req_if.rx_byte);
            bytes_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
               req_if.valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (rx_bytes_pending.size() != 0) begin
               req_if.valid <= 1'b1;
               req_if.rx_byte <= rx_bytes_pending.pop_front();
               gap_left <= pick_gap(sender_calm);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: random stalls, compares each frame byte with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen_beat.data = rsp_if.frame_byte;
            seen_beat.pos  = rsp_if.byte_position;
            seen_beat.last = rsp_if.last_of_frame;
            if (frame_beats_due.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: unexpected frame byte %h pos %0d last %0b", $time,
                           seen_beat.data, seen_beat.pos, seen_beat.last);
            end else begin
               due_beat = frame_beats_due.pop_front();
               beats_checked++;
               if (seen_beat !== due_beat) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("%0t: expected %h pos %0d last %0b, got %h pos %0d last %0b",
                              $time, due_beat.data, due_beat.pos, due_beat.last,
                              seen_beat.data, seen_beat.pos, seen_beat.last);
               end
            end
         end
         if (stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left <= pick_gap(receiver_calm);
         end
      end
   end

   // watchdog on cycles without any handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit counted);
      rx_bytes_pending.push_back(b);
      if (counted) items_queued++;
   endtask

   // complete frame with random payload, checksum good or corrupted
   task automatic send_frame(input int len, input bit good);
      logic [BYTE_W-1:0] chk;
      logic [BYTE_W-1:0] b;
      int i;
      chk = cfg_first + cfg_second + BYTE_W'(len);
      send_byte(cfg_first, 1'b1);
      send_byte(cfg_second, 1'b1);
      send_byte(BYTE_W'(len), 1'b1);
      for (i = 0; i < len; i++) begin
         b = BYTE_W'($urandom);
         chk = chk + b;
         send_byte(b, 1'b1);
      end
      send_byte(good ? chk : chk + BYTE_W'($urandom_range(1, 255)), 1'b1);
   endtask

   function automatic int pick_len();
      int lim;
      lim = eff_limit();
      if ($urandom_range(0, 99) < 80) return $urandom_range(0, (lim < 6) ? lim : 6);
      return $urandom_range(0, lim);
   endfunction

   // noise and frames that break off early
   task automatic send_broken();
      int lim;
      int i;
      int n;
      lim = eff_limit();
      case ($urandom_range(0, 4))
         0: begin  // line noise while hunting
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) send_byte(BYTE_W'($urandom), 1'b0);
         end
         1: begin  // wrong second header
            send_byte(cfg_first, 1'b1);
            send_byte(cfg_second ^ BYTE_W'($urandom_range(1, 255)), 1'b1);
         end
         2: begin  // length above the limit
            send_byte(cfg_first, 1'b1);
            send_byte(cfg_second, 1'b1);
            send_byte(BYTE_W'($urandom_range(lim + 1, 255)), 1'b1);
         end
         3: begin  // cut short, later bytes land in its payload
            n = (lim == 0) ? 0 : $urandom_range(1, lim);
            send_byte(cfg_first, 1'b1);
            send_byte(cfg_second, 1'b1);
            send_byte(BYTE_W'(n), 1'b1);
            for (i = 0; i < n / 2; i++) send_byte(BYTE_W'($urandom), 1'b1);
         end
         default: begin  // first header repeated in the second header slot
            send_byte(cfg_first, 1'b1);
            send_byte(cfg_first, 1'b1);
         end
      endcase
   endtask

   // hold until every queued byte is taken and every predicted frame byte has come
   task automatic wait_drained();
      while (rx_bytes_pending.size() != 0 || req_if.valid || frame_beats_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_FIRST_HEADER:  cfg_first  = val;
         CSR_SECOND_HEADER: cfg_second = val;
         CSR_PAYLOAD_LIMIT: cfg_limit  = val[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_registers(input logic [BYTE_W-1:0] hdr0, input logic [BYTE_W-1:0] hdr1,
                                input logic [CSR_DATA_W-1:0] lim_raw);
      settle();
      write_csr(CSR_FIRST_HEADER, hdr0);
      write_csr(CSR_SECOND_HEADER, hdr1);
      write_csr(CSR_PAYLOAD_LIMIT, lim_raw);
   endtask

   // mostly complete frames, the rest broken; now and then the sender waits out the readout
   task automatic random_traffic(input int n_items);
      int target;
      target = items_queued + n_items;
      while (items_queued < target) begin
         if ($urandom_range(0, 99) < 75) begin
            send_frame(pick_len(), $urandom_range(0, 99) < 85);
            if ($urandom_range(0, 9) == 0) wait_drained();
         end else begin
            send_broken();
         end
      end
   endtask

   // stimulus
   initial begin
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values: zero length, header slip, byte extremes, long length, bad sum
      send_frame(0, 1'b1);
      send_byte(cfg_first, 1'b1);
      send_byte(cfg_first, 1'b1);
      send_byte(cfg_second, 1'b1);
      send_byte(cfg_first, 1'b1);
      send_byte(cfg_second, 1'b1);
      send_byte(8'd2, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(cfg_first + cfg_second + 8'd2 + 8'hFF, 1'b1);
      send_byte(cfg_first, 1'b1);
      send_byte(cfg_second, 1'b1);
      send_byte(BYTE_W'(eff_limit() + 1), 1'b1);
      send_frame(1, 1'b0);
      wait_drained();

      // limit above the store saturates: longest frame passes, one more is dropped
      set_registers(8'h00, 8'hFF, 8'hFF);
      sender_calm   = 1'b1;
      receiver_calm = 1'b1;
      send_frame(MAX_LIMIT, 1'b1);
      send_byte(cfg_first, 1'b1);
      send_byte(cfg_second, 1'b1);
      send_byte(BYTE_W'(MAX_LIMIT + 1), 1'b1);
      random_traffic(50);

      // zero limit: only empty frames pass
      set_registers(8'hFF, 8'h00, 8'hE0);
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;
      send_frame(0, 1'b1);
      send_byte(cfg_first, 1'b1);
      send_byte(cfg_second, 1'b1);
      send_byte(8'd1, 1'b1);
      random_traffic(50);

      // both headers equal, unmapped register index written too
      set_registers(8'h7E, 8'h7E, CSR_DATA_W'($urandom_range(1, 28)));
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      sender_calm = 1'b1;
      random_traffic(50);

      // random settings
      set_registers(BYTE_W'($urandom), BYTE_W'($urandom), CSR_DATA_W'($urandom));
      sender_calm   = 1'b0;
      receiver_calm = 1'b1;
      random_traffic(50);
      set_registers(BYTE_W'($urandom), BYTE_W'($urandom), CSR_DATA_W'($urandom));
      sender_calm   = ($urandom_range(0, 3) == 0);
      receiver_calm = ($urandom_range(0, 3) == 0);
      random_traffic(50);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d received bytes over %0d register writes, %0d frames passed",
               bytes_taken, csr_writes, frames_passed);
      $display("%0d frame bytes checked, %0d mismatches", beats_checked, errors);
      if (errors == 0 && frame_beats_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
